/* rtl/fpa_pkg.sv */
package fpa_pkg;
	localparam int FRAC_BITS = 8;
	localparam int VW = 32;
	localparam int PW = 2 * VW;
	localparam int NW = VW + FRAC_BITS;
	localparam int QD = 4;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_GT = 4'd4;
	localparam logic [3:0] OP_LT = 4'd5;
	localparam logic [3:0] OP_GE = 4'd6;
	localparam logic [3:0] OP_LE = 4'd7;
	localparam logic [3:0] OP_EQ = 4'd8;
	localparam logic [3:0] OP_NE = 4'd9;
	localparam logic [3:0] OP_MIN = 4'd10;
	localparam logic [3:0] OP_MAX = 4'd11;
	localparam logic [3:0] OP_INC = 4'd12;
	localparam logic [3:0] OP_DEC = 4'd13;
	localparam logic [3:0] OP_FINT = 4'd14;
	localparam logic [3:0] OP_TINT = 4'd15;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_OVF = 2'd1;
	localparam logic [1:0] ERR_DIV0 = 2'd2;

	localparam logic signed [VW-1:0] MAX_V = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] MIN_V = {1'b1, {(VW-1){1'b0}}};

	// Front classifies each item: mul and nonzero div go back, the rest end here.
	localparam logic [1:0] K_DONE = 2'd0;
	localparam logic [1:0] K_MUL = 2'd1;
	localparam logic [1:0] K_DIV = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic neg;
		logic [VW-1:0] ma;
		logic [VW-1:0] mb;
		logic signed [VW-1:0] value;
		logic cmp;
		logic [1:0] err;
	} task_t;

	typedef struct packed {
		logic signed [VW-1:0] value;
		logic cmp;
		logic [1:0] err;
	} res_t;

	typedef struct packed {
		logic [3:0] op;
		logic signed [VW-1:0] a;
		logic signed [VW-1:0] b;
	} req_t;
endpackage

/* rtl/fpa_if.sv */
interface fpa_req_if import fpa_pkg::*; ();
	logic valid;
	logic ready;
	logic [3:0] op;
	logic signed [VW-1:0] operand_a;
	logic signed [VW-1:0] operand_b;
	modport source (output valid, op, operand_a, operand_b, input ready);
	modport sink (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fpa_res_if import fpa_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VW-1:0] result_value;
	logic compare_true;
	logic [1:0] error_code;
	modport source (output valid, result_value, compare_true, error_code, input ready);
	modport sink (input valid, result_value, compare_true, error_code, output ready);
endinterface

/* rtl/fpa_front.sv */
module fpa_front import fpa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input req_t in_req,
	output logic t_valid,
	input logic t_ready,
	output task_t t_data
);
	logic v_q;
	task_t t_q;
	task_t t_d;
	logic signed [VW:0] ax, bx, sum, dif;
	logic lt, eq;
	logic signed [VW-FRAC_BITS-1:0] top;

	function automatic logic signed [VW-1:0] sat(input logic signed [VW:0] x,
			output logic ovf);
		ovf = 1'b0;
		if (x > $signed({1'b0, MAX_V})) begin
			ovf = 1'b1;
			return MAX_V;
		end
		if (x < $signed({1'b1, MIN_V})) begin
			ovf = 1'b1;
			return MIN_V;
		end
		return x[VW-1:0];
	endfunction

	always_comb begin
		logic o;
		ax = {in_req.a[VW-1], in_req.a};
		bx = {in_req.b[VW-1], in_req.b};
		sum = ax + bx;
		dif = ax - bx;
		lt = in_req.a < in_req.b;
		eq = in_req.a == in_req.b;
		top = in_req.a[VW-1:FRAC_BITS];
		o = 1'b0;
		t_d = '0;
		t_d.kind = K_DONE;
		t_d.neg = in_req.a[VW-1] ^ in_req.b[VW-1];
		t_d.ma = in_req.a[VW-1] ? VW'(-in_req.a) : in_req.a;
		t_d.mb = in_req.b[VW-1] ? VW'(-in_req.b) : in_req.b;
		unique case (in_req.op)
			OP_ADD: t_d.value = sat(sum, o);
			OP_SUB: t_d.value = sat(dif, o);
			OP_MUL: t_d.kind = K_MUL;
			OP_DIV: begin
				t_d.kind = K_DIV;
				if (in_req.b == '0) begin
					t_d.kind = K_DONE;
					t_d.err = ERR_DIV0;
					t_d.value = in_req.a[VW-1] ? MIN_V : MAX_V;
				end
			end
			OP_GT: t_d.cmp = !lt && !eq;
			OP_LT: t_d.cmp = lt;
			OP_GE: t_d.cmp = !lt;
			OP_LE: t_d.cmp = lt || eq;
			OP_EQ: t_d.cmp = eq;
			OP_NE: t_d.cmp = !eq;
			OP_MIN: t_d.value = lt ? in_req.a : in_req.b;
			OP_MAX: t_d.value = (!lt && !eq) ? in_req.a : in_req.b;
			OP_INC: t_d.value = sat(ax + (VW+1)'(1), o);
			OP_DEC: t_d.value = sat(ax - (VW+1)'(1), o);
			OP_FINT: begin
				// Upper bits beyond the shifted width must all match the sign.
				if (!in_req.a[VW-1] && in_req.a[VW-2:VW-FRAC_BITS-1] != '0) begin
					o = 1'b1;
					t_d.value = MAX_V;
				end else if (in_req.a[VW-1] &&
						in_req.a[VW-2:VW-FRAC_BITS-1] != '1) begin
					o = 1'b1;
					t_d.value = MIN_V;
				end else begin
					t_d.value = {in_req.a[VW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
				end
			end
			default: t_d.value = VW'(top);
		endcase
		if (o) t_d.err = ERR_OVF;
	end

	assign in_ready = !v_q || t_ready;
	assign t_valid = v_q;
	assign t_data = t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) t_q <= t_d;
	end
endmodule

/* rtl/fpa_queue.sv */
module fpa_queue import fpa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic w_valid,
	output logic w_ready,
	input task_t w_data,
	output logic r_valid,
	input logic r_ready,
	output task_t r_data
);
	localparam int AW = $clog2(QD);
	task_t mem [QD];
	logic [AW:0] wp_q, rp_q;
	logic full, empty;

	assign full = (wp_q[AW] != rp_q[AW]) && (wp_q[AW-1:0] == rp_q[AW-1:0]);
	assign empty = wp_q == rp_q;
	assign w_ready = !full;
	assign r_valid = !empty;
	assign r_data = mem[rp_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (w_valid && !full) wp_q <= wp_q + 1'b1;
			if (r_ready && !empty) rp_q <= rp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (w_valid && !full) mem[wp_q[AW-1:0]] <= w_data;
	end

	property p_no_ovr;
		@(posedge clk) disable iff (!arst_n) full |=> !empty;
	endproperty
	a_no_ovr: assert property (p_no_ovr) else $error("queue lost items");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(w_valid && !full && !(r_ready && !empty)) |=> !empty)
		else $error("write did not land");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q - rp_q) <= (AW+1)'(QD)) else $error("queue count out of range");
endmodule

/* rtl/fpa_back.sv */
module fpa_back import fpa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic t_valid,
	output logic t_ready,
	input task_t t_data,
	output logic o_valid,
	input logic o_ready,
	output res_t o_data
);
	// Stage 0 registers the task, stages 1 to NW each resolve one quotient bit, and two
	// trailing stages carry the result, the last of them driving the output.
	localparam int NS = NW + 2;
	logic adv;
	logic v [NS+1];
	task_t tk [NS+1];
	logic [NW-1:0] qr [NS+1];
	logic [VW:0] rm [NS+1];
	logic [NW-1:0] num;

	assign adv = !o_valid || o_ready;
	assign t_ready = adv;
	assign num = {t_data.ma, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NS; i++) v[i] <= 1'b0;
		end else if (adv) begin
			v[0] <= t_valid;
			for (int i = 1; i <= NS; i++) v[i] <= v[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tk[0] <= t_data;
			qr[0] <= num;
			rm[0] <= '0;
			for (int i = 1; i < NW + 1; i++) begin
				logic [VW:0] r;
				r = {rm[i-1][VW-1:0], qr[i-1][NW-1]};
				tk[i] <= tk[i-1];
				if (r >= {1'b0, tk[i-1].mb}) begin
					rm[i] <= r - {1'b0, tk[i-1].mb};
					qr[i] <= {qr[i-1][NW-2:0], 1'b1};
				end else begin
					rm[i] <= r;
					qr[i] <= {qr[i-1][NW-2:0], 1'b0};
				end
			end
			tk[NW+1] <= tk[NW];
			qr[NW+1] <= qr[NW];
			rm[NW+1] <= rm[NW];
			tk[NS] <= tk[NS-1];
			qr[NS] <= qr[NS-1];
			rm[NS] <= rm[NS-1];
		end
	end

	// Multiply product is aligned with stage 1; carry it in step with the divide lanes.
	logic [PW-1:0] pl [NS+1];
	always_ff @(posedge clk) begin
		if (adv) begin
			pl[1] <= tk[0].ma * tk[0].mb;
			for (int i = 2; i <= NS; i++) pl[i] <= pl[i-1];
		end
	end

	always_comb begin
		logic [PW:0] pr;
		logic [PW:0] mag;
		logic [NW:0] q;
		logic [PW:0] lim;
		task_t t;
		t = tk[NS];
		lim = (PW+1)'(MAX_V) + (PW+1)'(t.neg);
		mag = '0;
		pr = {1'b0, pl[NS]} + (PW+1)'(1 << (FRAC_BITS - 1));
		q = {1'b0, qr[NS]} + (NW+1)'(rm[NS] >= ({1'b0, t.mb} - rm[NS]));
		o_data.cmp = t.cmp;
		o_data.err = t.err;
		o_data.value = t.value;
		if (t.kind == K_MUL) mag = pr >> FRAC_BITS;
		if (t.kind == K_DIV) mag = (PW+1)'(q);
		if (t.kind != K_DONE) begin
			if (mag > lim) begin
				o_data.err = ERR_OVF;
				o_data.value = t.neg ? MIN_V : MAX_V;
			end else begin
				o_data.value = t.neg ? VW'(-mag[VW-1:0]) : mag[VW-1:0];
			end
		end
	end

	assign o_valid = v[NS];
endmodule

/* rtl/fixed_point_alu.sv */
// Fixed-point ALU on signed Q24.8 raw values. Each accepted request yields one
// response in order; one transfer per cycle is sustained while the output is not
// stalled. Requests pass the front register, the four-entry queue and a 43-stage
// back pipeline set by the 40-step restoring divider; a stalled output holds the
// back pipeline. Multiply and divide round half away from zero; overflow
// saturates with error 1, divide by zero gives error 2.
module fixed_point_alu import fpa_pkg::*; (
	input logic clk,
	input logic arst_n,
	fpa_req_if.sink req,
	fpa_res_if.source res
);
	req_t r;
	logic fv, fr, qv, qr;
	task_t fd, qd;
	res_t od;
	logic ov;

	assign r.op = req.op;
	assign r.a = req.operand_a;
	assign r.b = req.operand_b;

	fpa_front u_front (.clk, .arst_n, .in_valid(req.valid), .in_ready(req.ready),
		.in_req(r), .t_valid(fv), .t_ready(fr), .t_data(fd));
	fpa_queue u_queue (.clk, .arst_n, .w_valid(fv), .w_ready(fr), .w_data(fd),
		.r_valid(qv), .r_ready(qr), .r_data(qd));
	fpa_back u_back (.clk, .arst_n, .t_valid(qv), .t_ready(qr), .t_data(qd),
		.o_valid(ov), .o_ready(res.ready), .o_data(od));

	assign res.valid = ov;
	assign res.result_value = od.value;
	assign res.compare_true = od.cmp;
	assign res.error_code = od.err;
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import fpa_pkg::*;

	typedef struct {
		logic [3:0] op;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} alu_req_t;

	typedef struct {
		logic signed [31:0] value;
		logic cmp;
		logic [1:0] err;
	} alu_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpa_req_if req ();
	fpa_res_if res ();

	fixed_point_alu DUT (.clk(clk), .arst_n(arst_n), .req(req.sink), .res(res.source));

	alu_req_t pending_ops[$];
	alu_res_t expected_results[$];
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_send = 1'b0;

	initial begin
		req.valid = 1'b0;
		req.op = '0;
		req.operand_a = '0;
		req.operand_b = '0;
		res.ready = 1'b0;
	end

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] saturate(logic signed [65:0] v, inout logic [1:0] err);
		if (v > 66'sd2147483647) begin
			err = ERR_OVF;
			return MAX_V;
		end
		if (v < -66'sd2147483648) begin
			err = ERR_OVF;
			return MIN_V;
		end
		return v[31:0];
	endfunction

	function automatic alu_res_t alu_predict(alu_req_t it);
		alu_res_t r;
		logic signed [65:0] a, b, p;
		logic [95:0] ma, mb, q, rem;
		logic neg;
		r.value = '0;
		r.cmp = 1'b0;
		r.err = ERR_OK;
		a = it.a;
		b = it.b;
		neg = (it.a < 0) != (it.b < 0);
		case (it.op)
			OP_ADD: r.value = saturate(a + b, r.err);
			OP_SUB: r.value = saturate(a - b, r.err);
			OP_MUL: begin
				ma = (a < 0) ? -a : a;
				mb = (b < 0) ? -b : b;
				q = (ma * mb + 96'd128) >> FRAC_BITS;
				p = neg ? -$signed({2'b0, q[63:0]}) : $signed({2'b0, q[63:0]});
				if (q > 96'h0FFFF_FFFF) p = neg ? -66'sd4294967296 : 66'sd4294967296;
				r.value = saturate(p, r.err);
			end
			OP_DIV: begin
				if (it.b == 0) begin
					r.err = ERR_DIV0;
					r.value = (it.a < 0) ? MIN_V : MAX_V;
				end else begin
					ma = (a < 0) ? -a : a;
					mb = (b < 0) ? -b : b;
					ma = ma << FRAC_BITS;
					q = ma / mb;
					rem = ma % mb;
					if (rem >= mb - rem) q = q + 1;
					p = neg ? -$signed({2'b0, q[63:0]}) : $signed({2'b0, q[63:0]});
					r.value = saturate(p, r.err);
				end
			end
			OP_GT: r.cmp = it.a > it.b;
			OP_LT: r.cmp = it.a < it.b;
			OP_GE: r.cmp = it.a >= it.b;
			OP_LE: r.cmp = it.a <= it.b;
			OP_EQ: r.cmp = it.a == it.b;
			OP_NE: r.cmp = it.a != it.b;
			OP_MIN: r.value = (it.a < it.b) ? it.a : it.b;
			OP_MAX: r.value = (it.a > it.b) ? it.a : it.b;
			OP_INC: r.value = saturate(a + 1, r.err);
			OP_DEC: r.value = saturate(a - 1, r.err);
			OP_FINT: r.value = saturate(a <<< FRAC_BITS, r.err);
			default: r.value = it.a >>> FRAC_BITS;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 4) - 2;
			3, 4: return $signed($urandom_range(0, 8191)) - 4096;
			5: return $signed($urandom_range(0, 2097151)) - 1048576;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
		alu_req_t it;
		it.op = op;
		it.a = a;
		it.b = b;
		pending_ops.push_back(it);
	endtask

	// Driver: a transfer happens when valid and ready are both high at the edge.
	// The item on the bus stays at the head of the queue until its transfer.
	always @(posedge clk) begin
		if (req.valid && req.ready) begin
			expected_results.push_back(alu_predict(pending_ops.pop_front()));
		end
		if (arst_n && !hold_send && pending_ops.size() > 0
				&& $urandom_range(0, 99) >= send_idle_pct) begin
			alu_req_t nx;
			nx = pending_ops[0];
			req.valid <= 1'b1;
			req.op <= nx.op;
			req.operand_a <= nx.a;
			req.operand_b <= nx.b;
		end else if (req.valid && req.ready || !req.valid) begin
			req.valid <= 1'b0;
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (res.valid && res.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %h", res.result_value);
			end else begin
				alu_res_t e;
				e = expected_results.pop_front();
				if (e.value !== res.result_value || e.cmp !== res.compare_true
						|| e.err !== res.error_code) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %h/%b/%0d, got %h/%b/%0d",
							e.value, e.cmp, e.err,
							res.result_value, res.compare_true, res.error_code);
				end
			end
		end
		res.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_ops.size() != 0 || req.valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// Extremes, every operation, division by zero and a zero dividend.
		for (int op = 0; op < 16; op++) queue_op(4'(op), 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_op(OP_SUB, 32'h0000_0000, 32'h8000_0000);
		queue_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		queue_op(OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
		queue_op(OP_DIV, 32'h0000_0000, 32'h0000_0000);
		queue_op(OP_DIV, 32'h8000_0000, 32'h0000_0000);
		queue_op(OP_DIV, 32'h8000_0000, 32'h0000_0001);
		queue_op(OP_DEC, 32'h8000_0000, 32'h0);
		queue_op(OP_FINT, 32'hFF80_0000, 32'h0);
		queue_op(OP_TINT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 46) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 46) : 0;
			for (int i = 0; i < 260; i++)
				queue_op(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
			if (ph == 1) begin
				repeat (30) @(posedge clk);
				hold_send = 1'b1;
				while (expected_results.size() != 0) @(posedge clk);
				hold_send = 1'b0;
			end
			wait_drained();
		end
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

/* filelist.f */
rtl/fpa_pkg.sv
rtl/fpa_if.sv
rtl/fpa_front.sv
rtl/fpa_queue.sv
rtl/fpa_back.sv
rtl/fixed_point_alu.sv
bench/tb_top.sv
